/* src/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_W           = 32;
  localparam int RESULT_W          = 64;
  localparam int STEP_W            = 7;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_REDUCE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD,
    S_DIV,
    S_DIVEND,
    S_DONE
  } state_t;

  // what a running division serves
  typedef enum logic [1:0] {
    PH_GCD,
    PH_QNUM,
    PH_QDEN
  } phase_t;

endpackage
`default_nettype wire

/* src/rau_if.sv */
// Request and response channel interfaces of the rational arithmetic unit.
`default_nettype none
interface rau_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] first_num;
  logic [31:0] first_den;
  logic [31:0] second_num;
  logic [31:0] second_den;
  modport source (output valid, op, first_num, first_den, second_num, second_den,
                  input ready);
  modport sink   (input valid, op, first_num, first_den, second_num, second_den,
                  output ready);
endinterface

interface rau_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_num;
  logic [63:0] result_den;
  logic        is_whole;
  logic [1:0]  status;
  modport source (output valid, result_num, result_den, is_whole, status,
                  input ready);
  modport sink   (input valid, result_num, result_den, is_whole, status,
                  output ready);
endinterface
`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit: cross products, Euclid reduction, shared serial divider.
//
//   channel | dir | fields
//   req     | in  | op, first_num, first_den, second_num, second_den
//   rsp     | out | result_num, result_den, is_whole, status
//
// One request at a time; req.ready is low from acceptance until the response leaves.
// Steps: the multiplier products and, for add and subtract, a sum step, then the
// Euclid remainder steps on the single 64-bit radix-2 divider (no division for a unit
// divisor) and the two final quotients on it, then the response register.
// Input errors go straight to the response. Reset (rst, synchronous) returns to idle.
// A stalled response holds in its register; no new request is taken meanwhile.
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  localparam int W  = OPERAND_WIDTH;
  localparam int RW = RESULT_W;

  state_t state, state_next;
  phase_t phase;

  logic [2:0]          op_r;
  logic signed [W-1:0] n1, d1, n2, d2;
  logic signed [RW-1:0] p, q, num, den, ea, eb;
  logic [1:0]          status;
  logic signed [RW-1:0] res_num, res_den;

  // divider registers
  logic [RW-1:0]     rem, quo, dvs;
  logic              qneg, rneg;
  logic [STEP_W-1:0] cnt;

  logic                 out_valid;
  logic                 accept;

  // operand views of the request
  logic signed [W-1:0] in_n1, in_d1, in_n2, in_d2;
  logic                in_reduce;
  assign in_n1     = req.first_num[W-1:0];
  assign in_d1     = req.first_den[W-1:0];
  assign in_n2     = req.second_num[W-1:0];
  assign in_d2     = req.second_den[W-1:0];
  assign in_reduce = (req.op > OP_DIV);

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign accept    = req.valid && req.ready;

  // shared multiplier, operands picked by step
  logic signed [W-1:0]   ma, mb;
  logic signed [2*W-1:0] prod;
  logic signed [RW-1:0]  prod64;
  always_comb begin
    ma = n1;
    mb = d2;
    unique case (state)
      S_MUL0: begin
        ma = n1;
        mb = (op_r == OP_MUL) ? n2 : d2;
      end
      S_MUL1: begin
        ma = n2;
        mb = d1;
      end
      S_MUL2: begin
        ma = d1;
        mb = (op_r == OP_DIV) ? n2 : d2;
      end
      default: begin
        ma = n1;
        mb = d2;
      end
    endcase
  end
  assign prod   = ma * mb;
  assign prod64 = RW'(prod);

  // sum or difference with overflow check
  logic signed [RW:0] sum;
  logic               sum_ovf;
  assign sum     = (op_r == OP_ADD) ? ({p[RW-1], p} + {q[RW-1], q})
                                    : ({p[RW-1], p} - {q[RW-1], q});
  assign sum_ovf = sum[RW] != sum[RW-1];

  // divider step
  logic [RW:0]   trial;
  logic [RW-1:0] rem_sh;
  assign rem_sh = {rem[RW-2:0], quo[RW-1]};
  assign trial  = {rem[RW-1], rem_sh} - {1'b0, dvs};

  logic signed [RW-1:0] div_q, div_r;
  assign div_q = qneg ? -$signed(quo) : $signed(quo);
  assign div_r = rneg ? -$signed(rem) : $signed(rem);

  // division launch
  logic                 div_go;
  logic signed [RW-1:0] div_a, div_b;
  phase_t               div_ph;

  logic eb_unit, gcd_ovf;
  localparam logic signed [RW-1:0] MIN64 = {1'b1, {(RW-1){1'b0}}};
  assign eb_unit = (eb == RW'(1)) || (eb == -RW'(1));
  assign gcd_ovf = ((num == MIN64) || (den == MIN64)) && (ea == -RW'(1));

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    div_a      = ea;
    div_b      = eb;
    div_ph     = PH_GCD;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_d1 == '0 || (!in_reduce && in_d2 == '0) ||
              (req.op == OP_DIV && in_n2 == '0)) begin
            state_next = S_DONE;
          end else if (in_reduce) begin
            state_next = S_GCD;
          end else begin
            state_next = S_MUL0;
          end
        end
      end
      S_MUL0:  state_next = (op_r == OP_ADD || op_r == OP_SUB) ? S_MUL1 : S_MUL2;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = (op_r == OP_ADD || op_r == OP_SUB) ? S_SUM : S_GCD;
      S_SUM:   state_next = sum_ovf ? S_DONE : S_GCD;
      S_GCD: begin
        priority if (eb == '0) begin
          if (gcd_ovf) begin
            state_next = S_DONE;
          end else begin
            div_go     = 1'b1;
            div_a      = num;
            div_b      = ea;
            div_ph     = PH_QNUM;
            state_next = S_DIV;
          end
        end else if (!eb_unit) begin
          div_go     = 1'b1;
          state_next = S_DIV;
        end else begin
          // unit divisor: one more pass settles the divisor
          state_next = S_GCD;
        end
      end
      S_DIV:   state_next = (cnt == STEP_W'(1)) ? S_DIVEND : S_DIV;
      S_DIVEND: begin
        unique case (phase)
          PH_GCD:  state_next = S_GCD;
          PH_QNUM: begin
            div_go     = 1'b1;
            div_a      = den;
            div_b      = ea;
            div_ph     = PH_QDEN;
            state_next = S_DIV;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // launch a division on magnitudes
    if (div_go) begin
      rem   <= '0;
      quo   <= div_a[RW-1] ? RW'(-div_a) : RW'(div_a);
      dvs   <= div_b[RW-1] ? RW'(-div_b) : RW'(div_b);
      qneg  <= div_a[RW-1] ^ div_b[RW-1];
      rneg  <= div_a[RW-1];
      cnt   <= STEP_W'(RW);
      phase <= div_ph;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r    <= req.op;
          n1      <= in_n1;
          d1      <= in_d1;
          n2      <= in_n2;
          d2      <= in_d2;
          num     <= RW'(in_n1);
          den     <= RW'(in_d1);
          ea      <= RW'(in_n1);
          eb      <= RW'(in_d1);
          res_num <= '0;
          res_den <= '0;
          priority if (in_d1 == '0 || (!in_reduce && in_d2 == '0)) begin
            status <= ST_ZERO_DEN;
          end else if (req.op == OP_DIV && in_n2 == '0) begin
            status <= ST_DIV_ZERO;
          end else begin
            status <= ST_OK;
          end
        end
      end
      S_MUL0: begin
        p   <= prod64;
        num <= prod64;
        ea  <= prod64;
      end
      S_MUL1: q <= prod64;
      S_MUL2: begin
        den <= prod64;
        eb  <= prod64;
      end
      S_SUM: begin
        num <= sum[RW-1:0];
        ea  <= sum[RW-1:0];
        if (sum_ovf) status <= ST_OVERFLOW;
      end
      S_GCD: begin
        if (eb == '0) begin
          if (gcd_ovf) status <= ST_OVERFLOW;
        end else if (eb_unit) begin
          ea <= eb;
          eb <= '0;
        end
      end
      S_DIV: begin
        cnt <= cnt - STEP_W'(1);
        if (!trial[RW]) begin
          rem <= trial[RW-1:0];
          quo <= {quo[RW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[RW-2:0], 1'b0};
        end
      end
      S_DIVEND: begin
        unique case (phase)
          PH_GCD: begin
            ea <= eb;
            eb <= div_r;
          end
          PH_QNUM: res_num <= div_q;
          default: res_den <= div_q;
        endcase
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      if (status == ST_OK) begin
        rsp.result_num <= res_num;
        rsp.result_den <= res_den;
        rsp.is_whole   <= (res_den == RW'(1));
      end else begin
        rsp.result_num <= '0;
        rsp.result_den <= '0;
        rsp.is_whole   <= 1'b0;
      end
      rsp.status <= status;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

/* test/rau_checker.sv */
// Checker for the rational arithmetic unit: predicts each response and compares it.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker
  import rau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rau_req_if        req,
  rau_rsp_if        rsp,
  output int        fail_count,
  output int        open_count
);

  typedef struct packed {
    logic [63:0] result_num;
    logic [63:0] result_den;
    logic        is_whole;
    status_t     status;
  } fraction_t;

  localparam longint MIN64 = 64'sh8000_0000_0000_0000;

  fraction_t fraction_q[$];
  int        errors;

  assign fail_count = errors;
  assign open_count = fraction_q.size();

  function automatic fraction_t error_fraction(status_t st);
    fraction_t r;
    r.result_num = '0;
    r.result_den = '0;
    r.is_whole   = 1'b0;
    r.status     = st;
    return r;
  endfunction

  // Euclid with truncating remainder; the divisor keeps whatever sign it ends with
  function automatic fraction_t reduce_fraction(longint num, longint den);
    longint    a;
    longint    b;
    longint    t;
    fraction_t r;
    a = num;
    b = den;
    while (b != 0) begin
      t = b;
      if (b == -1 || b == 1) b = 0;
      else b = a % b;
      a = t;
    end
    if ((num == MIN64 || den == MIN64) && a == -1) return error_fraction(ST_OVERFLOW);
    r.result_num = num / a;
    r.result_den = den / a;
    r.is_whole   = (den / a) == 1;
    r.status     = ST_OK;
    return r;
  endfunction

  function automatic fraction_t predict_fraction(logic [2:0] op, logic [31:0] n1r,
                                                  logic [31:0] d1r, logic [31:0] n2r,
                                                  logic [31:0] d2r);
    longint            n1;
    longint            d1;
    longint            n2;
    longint            d2;
    logic signed [64:0] wide;
    n1 = longint'($signed(n1r));
    d1 = longint'($signed(d1r));
    n2 = longint'($signed(n2r));
    d2 = longint'($signed(d2r));
    // codes past divide all reduce the first fraction
    if (op > OP_DIV) begin
      if (d1 == 0) return error_fraction(ST_ZERO_DEN);
      return reduce_fraction(n1, d1);
    end
    if (d1 == 0 || d2 == 0) return error_fraction(ST_ZERO_DEN);
    if (op == OP_DIV && n2 == 0) return error_fraction(ST_DIV_ZERO);
    case (op)
      OP_ADD, OP_SUB: begin
        if (op == OP_ADD) wide = 65'(signed'(n1 * d2)) + 65'(signed'(n2 * d1));
        else wide = 65'(signed'(n1 * d2)) - 65'(signed'(n2 * d1));
        if (wide[64] != wide[63]) return error_fraction(ST_OVERFLOW);
        return reduce_fraction(longint'(wide[63:0]), d1 * d2);
      end
      OP_MUL: return reduce_fraction(n1 * n2, d1 * d2);
      default: return reduce_fraction(n1 * d2, d1 * n2);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0d expected %0d", $time, what, $signed(got), $signed(want));
    errors++;
  endtask

  // queue a prediction per request, compare each response with the oldest one
  always @(posedge clk) begin
    fraction_t want;
    if (rst) begin
      errors = 0;
    end else begin
      if (req.valid && req.ready)
        fraction_q.push_back(predict_fraction(req.op, req.first_num, req.first_den,
                                              req.second_num, req.second_den));
      if (rsp.valid && rsp.ready) begin
        if (fraction_q.size() == 0) begin
          report_mismatch("response with none pending", 64'd0, 64'd0);
        end else begin
          want = fraction_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.result_num !== want.result_num)
            report_mismatch("result_num", rsp.result_num, want.result_num);
          if (rsp.result_den !== want.result_den)
            report_mismatch("result_den", rsp.result_den, want.result_den);
          if (rsp.is_whole !== want.is_whole)
            report_mismatch("is_whole", 64'(rsp.is_whole), 64'(want.is_whole));
        end
      end
    end
  end

  initial errors = 0;

endmodule
`default_nettype wire

/* test/tb.sv */
// Stimulus and verdict for the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rau_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int QUIET_FROM   = 170;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam logic [31:0] MAX32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  logic clk;
  logic rst;
  logic quiet;
  int   stall_left;
  int   fail_count;
  int   open_count;
  int   cycles;

  rau_req_if req ();
  rau_rsp_if rsp ();

  rational_arithmetic_unit i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  rau_checker i_checker (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                         .fail_count(fail_count), .open_count(open_count));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall the response side in short bursts, never once quiet
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp.ready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rsp.ready = 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      rsp.ready = 1'b1;
    end
  end

  // hold a request until it is taken
  task automatic send_request(logic [2:0] op, logic [31:0] n1, logic [31:0] d1,
                              logic [31:0] n2, logic [31:0] d2);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    req.valid      = 1'b1;
    req.op         = op;
    req.first_num  = n1;
    req.first_den  = d1;
    req.second_num = n2;
    req.second_den = d2;
    #1;
    while (!req.ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return 32'($signed($urandom_range(0, 40)) - 20);
      1:       return $urandom();
      2:       return $urandom_range(0, 1) ? MAX32 : MIN32;
      3:       return 32'($urandom_range(1, 12) * 64'(1 << $urandom_range(0, 20)));
      4:       return 32'd0;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [31:0] pick_divisor();
    logic [31:0] v;
    v = pick_operand();
    if (v == 0 && $urandom_range(0, 3) != 0) v = 32'd1;
    return v;
  endfunction

  initial begin
    logic [2:0] op;
    rst        = 1'b1;
    quiet      = 1'b0;
    stall_left = 0;
    rsp.ready  = 1'b0;
    req.valid  = 1'b0;
    req.op     = OP_ADD;
    req.first_num  = '0;
    req.first_den  = '0;
    req.second_num = '0;
    req.second_den = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every operation, extremes and the error cases
    send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_request(OP_MUL, 32'd6, 32'd4, -32'sd2, 32'd3);
    send_request(OP_DIV, 32'd3, 32'd4, 32'd9, -32'sd8);
    send_request(OP_REDUCE, 32'd12, -32'sd18, 32'd0, 32'd0);
    send_request(OP_REDUCE, 32'd0, -32'sd7, MAX32, MIN32);
    send_request(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
    send_request(OP_MUL, 32'd5, 32'd3, 32'd1, 32'd0);
    send_request(OP_REDUCE, 32'd5, 32'd0, 32'd1, 32'd1);
    send_request(OP_DIV, 32'd5, 32'd3, 32'd0, 32'd7);
    send_request(OP_ADD, MIN32, MIN32, MIN32, MIN32);
    send_request(OP_ADD, MIN32, 32'd1, MIN32, 32'd1);
    send_request(OP_SUB, MIN32, MIN32, MAX32, 32'd1);
    send_request(OP_SUB, MAX32, MIN32, MIN32, MIN32);
    send_request(OP_MUL, MIN32, MAX32, MIN32, MAX32);
    send_request(OP_DIV, MAX32, MIN32, MIN32, MAX32);
    send_request(OP_REDUCE, MIN32, -32'sd1, 32'd0, 32'd0);
    send_request(3'd5, 32'd8, 32'd4, 32'd1, 32'd0);
    send_request(3'd6, -32'sd9, 32'd3, 32'd0, 32'd0);
    send_request(3'd7, 32'd7, 32'd7, MAX32, MAX32);
    send_request(OP_MUL, 32'd0, 32'd5, 32'd9, 32'd3);
    send_request(OP_REDUCE, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);

    // hold off until every pending response is back
    while (open_count != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      op = 3'($urandom_range(0, 7));
      send_request(op, pick_operand(), pick_divisor(), pick_operand(), pick_divisor());
    end

    quiet = 1'b1;
    while (open_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // guard against a hang
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
